>>> rtl/core/ajmp_pkg.sv
`timescale 1ns / 1ps
// ajmp_pkg: shared widths, constants, codes and control structs for the axis jog/move profile
// generator. No dependencies; imported by every module of the block.
package ajmp_pkg;

  localparam int POSITION_BITS_DEF = 28;
  localparam int VELOCITY_BITS_DEF = 21;

  localparam int ACCEL_BITS   = 24;
  localparam int TIMEOUT_BITS = 24;
  localparam int IDLE_BITS    = 25;
  localparam int DT_BITS      = 20;
  localparam int CMD_BITS     = 2;
  localparam int DIR_BITS     = 2;
  localparam int CFG_IDX_BITS = 3;

  localparam longint US_PER_S = 1000000;
  localparam longint HALF_US  = 500000;

  // one million is 2^6 times an odd part below 2^14
  localparam int     DIV_SHIFT    = 6;
  localparam longint DIV_ODD      = US_PER_S >> DIV_SHIFT;
  localparam int     DIV_ODD_BITS = 14;

  localparam int POS_TOL      = 10;
  localparam int VEL_STOP_TOL = 100;
  localparam int VEL_ERR_TOL  = 10;

  localparam longint RST_MAX_VEL = 100000;
  localparam longint RST_ACCEL   = 500000;
  localparam longint RST_MIN_POS = -1000000;
  localparam longint RST_MAX_POS = 1000000;
  localparam longint RST_TIMEOUT = 200000;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK = 2'd0,
    CMD_JOG  = 2'd1,
    CMD_MOVE = 2'd2,
    CMD_NOP  = 2'd3
  } ajmp_op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAX_VEL = 3'd0,
    REG_ACCEL   = 3'd1,
    REG_MIN_POS = 3'd2,
    REG_MAX_POS = 3'd3,
    REG_TIMEOUT = 3'd4
  } ajmp_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_START1,
    ST_RUN1,
    ST_VEL,
    ST_MULV,
    ST_START2,
    ST_RUN2,
    ST_POS,
    ST_DONE
  } ajmp_state_t;

  typedef struct packed {
    logic take;
    logic do_jog;
    logic do_move;
    logic tick_prep;
    logic start1;
    logic vel_upd;
    logic mulv;
    logic start2;
    logic pos_upd;
    logic load_out;
  } ajmp_cmd_t;

  typedef struct packed {
    ajmp_op_t op;
    logic     div_busy;
    logic     mul_busy;
  } ajmp_stat_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // config data port is as wide as the widest register
  function automatic int cfg_width(input int p, input int v);
    return imax(imax(p, ACCEL_BITS), imax(TIMEOUT_BITS, v - 1));
  endfunction

  // dividend of the divide-by-one-million unit: a*dt or |v|*dt, plus the rounding half
  function automatic int div_dw(input int v);
    return imax(ACCEL_BITS + DT_BITS + 1, v + DT_BITS);
  endfunction

  function automatic int div_qw(input int v);
    return imax(ACCEL_BITS + 1, v);
  endfunction

endpackage

>>> rtl/core/axis_jog_move_profile_top.sv
`timescale 1ns / 1ps
// A tick makes two passes through the divide-by-1e6 unit between accept and out_valid. When a
// move is active, off target and acceleration is not zero, the serial brake product runs
// beside the first pass and sets the time. Jog, move-to and unknown skip the arithmetic.
// Throughput: one transaction at a time, the next is accepted the cycle after the result
// is loaded into the output register. Reset (rst_n low, synchronous) restores the default
// limits and clears position, velocity, jog and move state; the key idle timer saturates.
module axis_jog_move_profile_top
  import ajmp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                cfg_index,
  input  logic [cfg_width(POSITION_BITS, VELOCITY_BITS)-1:0] cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [CMD_BITS-1:0]                    in_command,
  input  logic [DT_BITS-1:0]                     in_dt_us,
  input  logic signed [DIR_BITS-1:0]             in_direction,
  input  logic signed [POSITION_BITS-1:0]        in_target,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [POSITION_BITS-1:0]        out_position,
  output logic signed [VELOCITY_BITS-1:0]        out_velocity,
  output logic                                   out_moving_to_target
);

  ajmp_cmd_t  cmd;
  ajmp_stat_t stat;

  ajmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ajmp_dp #(
    .POSITION_BITS (POSITION_BITS),
    .VELOCITY_BITS (VELOCITY_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_command           (in_command),
    .in_dt_us             (in_dt_us),
    .in_direction         (in_direction),
    .in_target            (in_target),
    .out_position         (out_position),
    .out_velocity         (out_velocity),
    .out_moving_to_target (out_moving_to_target),
    .cmd                  (cmd),
    .stat                 (stat)
  );

endmodule

>>> rtl/core/ajmp_ctrl.sv
`timescale 1ns / 1ps
// ajmp_ctrl: sequencing state machine and output handshake for the profile generator.
// Depends on ajmp_pkg; drives ajmp_dp through ajmp_cmd_t and watches ajmp_stat_t.
module ajmp_ctrl
  import ajmp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output ajmp_cmd_t  cmd,
  input  ajmp_stat_t stat
);

  ajmp_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall      = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.op)
          CMD_TICK: begin
            cmd.tick_prep = 1'b1;
            state_nxt     = ST_START1;
          end
          CMD_JOG: begin
            cmd.do_jog = 1'b1;
            state_nxt  = ST_DONE;
          end
          CMD_MOVE: begin
            cmd.do_move = 1'b1;
            state_nxt   = ST_DONE;
          end
          CMD_NOP: state_nxt = ST_DONE;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_START1: begin
        cmd.start1 = 1'b1;
        state_nxt  = ST_RUN1;
      end
      ST_RUN1: begin
        if (!stat.div_busy && !stat.mul_busy) state_nxt = ST_VEL;
      end
      ST_VEL: begin
        cmd.vel_upd = 1'b1;
        state_nxt   = ST_MULV;
      end
      ST_MULV: begin
        cmd.mulv  = 1'b1;
        state_nxt = ST_START2;
      end
      ST_START2: begin
        cmd.start2 = 1'b1;
        state_nxt  = ST_RUN2;
      end
      ST_RUN2: begin
        if (!stat.div_busy) state_nxt = ST_POS;
      end
      ST_POS: begin
        cmd.pos_upd = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        // output register free or being taken this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_div_started: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_START1 || state_r == ST_START2) |=> stat.div_busy)
    else $error("divider did not start");

  a_vel_inputs_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_VEL) |-> (!stat.div_busy && !stat.mul_busy))
    else $error("velocity update before ramp step and brake product are ready");

  a_mul_idle_phase2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN2) |-> !stat.mul_busy)
    else $error("brake multiplier still running in position phase");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside of done state");
`endif

endmodule

>>> rtl/core/ajmp_cdiv.sv
`timescale 1ns / 1ps
// ajmp_cdiv: divide by the constant one million with a reciprocal multiply and a single
// correction step, done in registered phases. Depends on ajmp_pkg for the divisor constants.
module ajmp_cdiv
  import ajmp_pkg::*;
#(
  parameter int DW = div_dw(VELOCITY_BITS_DEF),
  parameter int QW = div_qw(VELOCITY_BITS_DEF)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  // drop the power-of-two part, then divide by the odd part
  localparam int NDW  = DW - DIV_SHIFT;
  localparam int LO_W = NDW / 2;
  localparam int HI_W = NDW - LO_W;
  localparam int MW   = NDW - DIV_ODD_BITS + 1;
  localparam int PHW  = HI_W + MW;
  localparam int PLW  = LO_W + MW;
  localparam int PW   = NDW + MW + 1;
  localparam int QDW  = QW + DIV_ODD_BITS;
  localparam int RW   = DIV_ODD_BITS + 1;
  // floor(2^NDW / odd part): the estimate comes out low by at most one
  localparam logic [MW-1:0] RECIP = MW'((longint'(1) << NDW) / DIV_ODD);

  logic [NDW-1:0] nd_r;
  logic [PHW-1:0] phi_r;
  logic [PLW-1:0] plo_r;
  logic [QW-1:0]  q0_r, q_r;
  logic [RW-1:0]  rem_r;
  logic [3:0]     ph_r;
  logic [PW-1:0]  psum;
  logic [QDW-1:0] qd;

  assign psum = (PW'(phi_r) << LO_W) + PW'(plo_r);
  assign qd   = QDW'(q0_r) * QDW'(DIV_ODD);

  // phases: partial products, estimate, remainder, correction
  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= '0;
    else if (start) ph_r <= 4'b0001;
    else ph_r <= {ph_r[2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (start) nd_r <= dividend[DW-1:DIV_SHIFT];
    if (ph_r[0]) begin
      phi_r <= PHW'(nd_r[NDW-1:LO_W]) * PHW'(RECIP);
      plo_r <= PLW'(nd_r[LO_W-1:0]) * PLW'(RECIP);
    end
    if (ph_r[1]) q0_r <= QW'(psum[PW-1:NDW]);
    // true remainder is below twice the odd part, so the low bits are enough
    if (ph_r[2]) rem_r <= nd_r[RW-1:0] - qd[RW-1:0];
    if (ph_r[3]) q_r <= q0_r + QW'(rem_r >= RW'(DIV_ODD));
  end

  assign busy     = |ph_r;
  assign quotient = q_r;

endmodule

>>> rtl/core/ajmp_dp.sv
`timescale 1ns / 1ps
// ajmp_dp: config registers, axis state, brake product, ramp and position arithmetic.
// Depends on ajmp_pkg and ajmp_cdiv; sequenced by ajmp_ctrl.
module ajmp_dp
  import ajmp_pkg::*;
#(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VELOCITY_BITS = VELOCITY_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                cfg_index,
  input  logic [cfg_width(POSITION_BITS, VELOCITY_BITS)-1:0] cfg_data,
  input  logic [CMD_BITS-1:0]                    in_command,
  input  logic [DT_BITS-1:0]                     in_dt_us,
  input  logic signed [DIR_BITS-1:0]             in_direction,
  input  logic signed [POSITION_BITS-1:0]        in_target,
  output logic signed [POSITION_BITS-1:0]        out_position,
  output logic signed [VELOCITY_BITS-1:0]        out_velocity,
  output logic                                   out_moving_to_target,
  input  ajmp_cmd_t                              cmd,
  output ajmp_stat_t                             stat
);

  localparam int P      = POSITION_BITS;
  localparam int V      = VELOCITY_BITS;
  localparam int AVW    = V - 1;
  localparam int EW1    = P + 1;
  localparam int VEW    = V + 1;
  localparam int MACC_W = P + ACCEL_BITS;
  localparam int VSQ_W  = 2 * AVW;
  localparam int BCMP_W = imax(MACC_W + 1, VSQ_W);
  localparam int ADT_W  = ACCEL_BITS + DT_BITS;
  localparam int VDT_W  = AVW + DT_BITS;
  localparam int DW     = div_dw(V);
  localparam int QW     = div_qw(V);
  localparam int NW     = imax(V, QW) + 2;
  localparam int SW     = imax(P, QW) + 2;
  localparam int IDW1   = IDLE_BITS + 1;
  localparam int MCNT_W = $clog2(ACCEL_BITS);

  // configuration
  logic [AVW-1:0]          max_vel_r;
  logic [ACCEL_BITS-1:0]   accel_r;
  logic signed [P-1:0]     min_pos_r, max_pos_r;
  logic [TIMEOUT_BITS-1:0] timeout_r;

  // latched item
  ajmp_op_t                op_r;
  logic [DT_BITS-1:0]      dt_r;
  logic signed [1:0]       dir_r;
  logic signed [P-1:0]     tgt_r;

  // axis state
  logic signed [P-1:0]     pos_r, goal_r;
  logic signed [V-1:0]     vel_r;
  logic signed [1:0]       jog_r;
  logic                    active_r;
  logic [IDLE_BITS-1:0]    idle_r;

  // tick intermediates
  logic [P-1:0]            ae_r;
  logic                    eneg_r;
  logic [AVW-1:0]          av_r;
  logic [VSQ_W-1:0]        vsq_r;
  logic [ADT_W-1:0]        adt_r;
  logic [VDT_W-1:0]        vdt_r;
  logic                    vneg_r;

  // serial brake multiplier: (|e| - tol) * accel
  logic [MACC_W-1:0]       macc_r, mx_r;
  logic [ACCEL_BITS-1:0]   ma_r;
  logic [MCNT_W-1:0]       mcnt_r;
  logic                    mul_busy_r;
  logic                    mul_need;

  // output register
  logic signed [P-1:0]     opos_r;
  logic signed [V-1:0]     ovel_r;
  logic                    omov_r;

  logic [DW-1:0]           div_dvd;
  logic [QW-1:0]           div_q;
  logic                    div_busy;

  logic [IDW1-1:0]         idle_sum;
  logic [IDLE_BITS-1:0]    idle_sat;
  logic signed [EW1-1:0]   err;
  logic [EW1-1:0]          err_abs;
  logic signed [V-1:0]     vabs_full;
  logic [AVW-1:0]          av;

  logic                    brake, stop;
  logic signed [1:0]       drive;
  logic signed [V-1:0]     vcur, tv, vel_new;
  logic signed [VEW-1:0]   ve;
  logic signed [NW-1:0]    dv_s, nv, tv_w;
  logic signed [SW-1:0]    step_s, pos_sum;

  function automatic logic signed [P-1:0] clamp_pos(input logic signed [SW-1:0] p,
                                                    input logic signed [P-1:0] lo_in,
                                                    input logic signed [P-1:0] hi_in);
    logic signed [SW-1:0] lo, hi, t;
    lo = SW'(lo_in);
    hi = SW'(hi_in);
    t  = (p > hi) ? hi : p;
    t  = (t < lo) ? lo : t;
    return t[P-1:0];
  endfunction

  ajmp_cdiv #(.DW(DW), .QW(QW)) u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start1 | cmd.start2),
    .dividend (div_dvd),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign div_dvd = cmd.start2 ? (DW'(vdt_r) + DW'(HALF_US)) : (DW'(adt_r) + DW'(HALF_US));

  assign stat.op       = op_r;
  assign stat.div_busy = div_busy;
  assign stat.mul_busy = mul_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vel_r <= AVW'(RST_MAX_VEL);
      accel_r   <= ACCEL_BITS'(RST_ACCEL);
      min_pos_r <= P'(RST_MIN_POS);
      max_pos_r <= P'(RST_MAX_POS);
      timeout_r <= TIMEOUT_BITS'(RST_TIMEOUT);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_VEL: max_vel_r <= cfg_data[AVW-1:0];
        REG_ACCEL:   accel_r   <= cfg_data[ACCEL_BITS-1:0];
        REG_MIN_POS: min_pos_r <= cfg_data[P-1:0];
        REG_MAX_POS: max_pos_r <= cfg_data[P-1:0];
        REG_TIMEOUT: timeout_r <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= ajmp_op_t'(in_command);
      dt_r  <= in_dt_us;
      dir_r <= in_direction;
      tgt_r <= in_target;
    end
  end

  // tick preparation terms
  assign idle_sum  = IDW1'(idle_r) + IDW1'(dt_r);
  assign idle_sat  = idle_sum[IDLE_BITS] ? '1 : idle_sum[IDLE_BITS-1:0];
  assign err       = EW1'(goal_r) - EW1'(pos_r);
  assign err_abs   = err[EW1-1] ? -err : err;
  assign vabs_full = vel_r[V-1] ? -vel_r : vel_r;
  assign av        = vabs_full[AVW-1:0];
  assign mul_need  = active_r && (ae_r > P'(POS_TOL)) && (accel_r != '0);

  // velocity update
  always_comb begin
    if (ae_r <= P'(POS_TOL)) brake = 1'b1;
    else if (accel_r == '0) brake = (av_r != '0);
    // |e| - tol <= v^2 / 2a  is  2a(|e| - tol) <= v^2
    else brake = (BCMP_W'({macc_r, 1'b0}) <= BCMP_W'(vsq_r));

    if (active_r) drive = brake ? 2'sb00 : (eneg_r ? 2'sb11 : 2'sb01);
    else drive = jog_r;

    stop = active_r && brake && (av_r < AVW'(VEL_STOP_TOL));
    vcur = stop ? '0 : vel_r;

    if (drive == 2'sb01) tv = $signed({1'b0, max_vel_r});
    else if (drive == 2'sb11) tv = -$signed({1'b0, max_vel_r});
    else tv = '0;

    ve   = VEW'(tv) - VEW'(vcur);
    dv_s = NW'(div_q);
    tv_w = NW'(tv);
    if (ve > 0) nv = NW'(vcur) + dv_s;
    else nv = NW'(vcur) - dv_s;

    if (ve > VEW'(VEL_ERR_TOL) || ve < -VEW'(VEL_ERR_TOL)) begin
      if ((ve > 0 && nv > tv_w) || (ve < 0 && nv < tv_w)) vel_new = tv;
      else vel_new = nv[V-1:0];
    end else begin
      vel_new = tv;
    end
  end

  assign step_s  = SW'(div_q);
  assign pos_sum = SW'(pos_r) + (vneg_r ? -step_s : step_s);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      vel_r    <= '0;
      jog_r    <= '0;
      goal_r   <= '0;
      active_r <= 1'b0;
      idle_r   <= '1;
    end else if (cmd.do_jog) begin
      active_r <= 1'b0;
      jog_r    <= (dir_r == 2'sb10) ? 2'sb11 : dir_r;
      idle_r   <= '0;
    end else if (cmd.do_move) begin
      goal_r   <= clamp_pos(SW'(tgt_r), min_pos_r, max_pos_r);
      active_r <= 1'b1;
      jog_r    <= '0;
    end else if (cmd.tick_prep) begin
      idle_r <= idle_sat;
      if (idle_sat > IDLE_BITS'(timeout_r)) jog_r <= '0;
    end else if (cmd.vel_upd) begin
      vel_r <= vel_new;
      if (stop) begin
        active_r <= 1'b0;
        pos_r    <= goal_r;
      end
    end else if (cmd.pos_upd) begin
      pos_r <= clamp_pos(pos_sum, min_pos_r, max_pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_prep) begin
      ae_r   <= err_abs[P-1:0];
      eneg_r <= err[EW1-1];
      av_r   <= av;
      vsq_r  <= VSQ_W'(av) * VSQ_W'(av);
      adt_r  <= ADT_W'(accel_r) * ADT_W'(dt_r);
    end
    if (cmd.mulv) begin
      vdt_r  <= VDT_W'(av) * VDT_W'(dt_r);
      vneg_r <= vel_r[V-1];
    end
  end

  // brake product, one accel bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mcnt_r     <= '0;
    end else if (cmd.start1) begin
      mul_busy_r <= mul_need;
      mcnt_r     <= '0;
    end else if (mul_busy_r) begin
      mcnt_r <= mcnt_r + MCNT_W'(1);
      if (mcnt_r == MCNT_W'(ACCEL_BITS - 1)) mul_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start1) begin
      macc_r <= '0;
      mx_r   <= MACC_W'(ae_r - P'(POS_TOL));
      ma_r   <= accel_r;
    end else if (mul_busy_r) begin
      if (ma_r[0]) macc_r <= macc_r + mx_r;
      mx_r <= mx_r << 1;
      ma_r <= ma_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      opos_r <= pos_r;
      ovel_r <= vel_r;
      omov_r <= active_r;
    end
  end

  assign out_position         = opos_r;
  assign out_velocity         = ovel_r;
  assign out_moving_to_target = omov_r;

endmodule
